>>> src/rmq_pkg.sv
// rmq_pkg: shared constants, codes and interface structs for the range min/max query engine
// depends on nothing; used by rmq_store and range_min_max_query_engine
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int GRP_LEN      = 1 << 10;
  localparam int NUM_GROUPS   = (SAMPLE_DEPTH + GRP_LEN - 1) / GRP_LEN;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int OFS_W        = $clog2(GRP_LEN);
  localparam int GRP_W        = $clog2(NUM_GROUPS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int SMP_W        = 8;
  localparam int IDX_W        = 16;

  localparam logic [SMP_W-1:0] SMP_MAX = 8'd255;
  localparam logic [SMP_W-1:0] SMP_MIN = 8'd0;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // one append: sample word plus the updated summary of its group
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  sample;
    logic [SMP_W-1:0]  grp_min;
    logic [SMP_W-1:0]  grp_max;
  } store_wr_t;

  // one scan read: a single sample or a whole-group summary
  typedef struct packed {
    logic              en;
    logic              grp;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic             vld;
    logic [SMP_W-1:0] lo;
    logic [SMP_W-1:0] hi;
  } store_rdata_t;

endpackage
`default_nettype wire

>>> src/range_min_max_query_engine.sv
// range_min_max_query_engine: sample append and range min/max query control
// depends on rmq_pkg and rmq_store
//
//   port group  dir  tdata (low bit up)                              tuser
//   s_*         in   sample_value, range_start, range_end (40 bits)  req_type
//   m_*         out  range_min, range_max (16 bits)                  status
//
// a load or a rejected query gives its result in the cycle after the request is taken
// a query reads the head, then whole groups, then the tail, where head and tail are
// single samples up to and after the group boundaries, and then passes S_DRAIN and S_FINISH
// reset empties the store (fill count zero); memory contents are left as they are
// a request is taken only when idle and when the result register is free or being drained
`timescale 1ns / 1ps
`default_nettype none
module range_min_max_query_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // sample_value[7:0], range_start[23:8], range_end[39:24]
  input  wire  [0:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // range_min[7:0], range_max[15:8]
  output logic [1:0]  m_tuser    // status
);

  localparam int CW = rmq_pkg::CNT_W;

  rmq_pkg::state_t state, state_next;

  logic [rmq_pkg::SMP_W-1:0] sample_value;
  logic [rmq_pkg::IDX_W-1:0] range_start;
  logic [rmq_pkg::IDX_W-1:0] range_end;
  logic                      req_type;

  logic [CW-1:0]             fill_count;
  logic [rmq_pkg::SMP_W-1:0] cur_min;
  logic [rmq_pkg::SMP_W-1:0] cur_max;
  logic [rmq_pkg::SMP_W-1:0] grp_min_next;
  logic [rmq_pkg::SMP_W-1:0] grp_max_next;

  logic [CW-1:0]             idx;
  logic [CW-1:0]             remaining;
  logic [CW-1:0]             step;
  logic                      use_grp;
  logic                      last_issue;

  logic [rmq_pkg::SMP_W-1:0] mn;
  logic [rmq_pkg::SMP_W-1:0] mx;
  logic [rmq_pkg::SMP_W-1:0] out_min;
  logic [rmq_pkg::SMP_W-1:0] out_max;
  rmq_pkg::status_t          out_status;

  logic accept;
  logic out_free;
  logic store_full;
  logic q_bad;
  logic quick_result;
  logic finish_result;

  rmq_pkg::store_wr_t    wr;
  rmq_pkg::store_rd_t    rd;
  rmq_pkg::store_rdata_t rdata;

  assign req_type     = s_tuser[0];
  assign sample_value = s_tdata[7:0];
  assign range_start  = s_tdata[23:8];
  assign range_end    = s_tdata[39:24];

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign store_full = (fill_count == CW'(rmq_pkg::SAMPLE_DEPTH));
  assign q_bad      = (range_start > range_end) || ({1'b0, range_end} >= fill_count);

  // greedy walk: whole groups only from an aligned index with more than a group left
  assign use_grp    = (idx[rmq_pkg::OFS_W-1:0] == '0) &&
                      (remaining > CW'(rmq_pkg::GRP_LEN));
  assign step       = use_grp ? CW'(rmq_pkg::GRP_LEN) : CW'(1);
  assign last_issue = (remaining == step);

  // the first sample of a group restarts its summary
  always_comb begin
    if (fill_count[rmq_pkg::OFS_W-1:0] == '0) begin
      grp_min_next = sample_value;
      grp_max_next = sample_value;
    end else begin
      grp_min_next = (sample_value < cur_min) ? sample_value : cur_min;
      grp_max_next = (sample_value > cur_max) ? sample_value : cur_max;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmq_pkg::S_IDLE: begin
        if (accept && req_type == rmq_pkg::REQ_QUERY && !q_bad) state_next = rmq_pkg::S_SCAN;
      end
      rmq_pkg::S_SCAN: begin
        if (last_issue) state_next = rmq_pkg::S_DRAIN;
      end
      rmq_pkg::S_DRAIN: begin
        state_next = rmq_pkg::S_FINISH;
      end
      rmq_pkg::S_FINISH: begin
        if (out_free) state_next = rmq_pkg::S_IDLE;
      end
      default: begin
        state_next = rmq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    rd            = '0;
    finish_result = 1'b0;
    unique case (state)
      rmq_pkg::S_IDLE: begin
        s_tready = out_free;
      end
      rmq_pkg::S_SCAN: begin
        rd.en   = 1'b1;
        rd.grp  = use_grp;
        rd.addr = idx[rmq_pkg::ADDR_W-1:0];
      end
      rmq_pkg::S_DRAIN: begin
      end
      rmq_pkg::S_FINISH: begin
        finish_result = out_free;
      end
      default: begin
      end
    endcase
  end

  assign quick_result = accept && (req_type == rmq_pkg::REQ_LOAD || q_bad);

  always_comb begin
    wr.en      = accept && req_type == rmq_pkg::REQ_LOAD && !store_full;
    wr.addr    = fill_count[rmq_pkg::ADDR_W-1:0];
    wr.sample  = sample_value;
    wr.grp_min = grp_min_next;
    wr.grp_max = grp_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rmq_pkg::S_IDLE;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (wr.en) begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cur_min <= grp_min_next;
      cur_max <= grp_max_next;
    end
    if (accept) begin
      idx       <= {1'b0, range_start};
      remaining <= CW'({1'b0, range_end} - {1'b0, range_start} + CW'(1));
      mn        <= rmq_pkg::SMP_MAX;
      mx        <= rmq_pkg::SMP_MIN;
    end else begin
      if (state == rmq_pkg::S_SCAN) begin
        idx       <= idx + step;
        remaining <= remaining - step;
      end
      if (rdata.vld) begin
        if (rdata.lo < mn) mn <= rdata.lo;
        if (rdata.hi > mx) mx <= rdata.hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (quick_result || finish_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (quick_result) begin
      out_min <= rmq_pkg::SMP_MIN;
      out_max <= rmq_pkg::SMP_MIN;
      if (req_type == rmq_pkg::REQ_QUERY) begin
        out_status <= rmq_pkg::ST_BAD_RANGE;
      end else if (store_full) begin
        out_status <= rmq_pkg::ST_FULL;
      end else begin
        out_status <= rmq_pkg::ST_DONE;
      end
    end else if (finish_result) begin
      out_min    <= mn;
      out_max    <= mx;
      out_status <= rmq_pkg::ST_DONE;
    end
  end

  assign m_tdata = {out_max, out_min};
  assign m_tuser = out_status;

  rmq_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(rmq_pkg::SAMPLE_DEPTH))
    else $error("fill count beyond store depth");

  a_scan_reads_loaded: assert property (@(posedge clk) disable iff (rst)
    state == rmq_pkg::S_SCAN |-> (idx + remaining) <= fill_count && remaining != '0)
    else $error("scan reaches past loaded samples");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rdata.vld |-> $past(state == rmq_pkg::S_SCAN))
    else $error("read data without a scan read");

  a_busy_no_request: assert property (@(posedge clk) disable iff (rst)
    state != rmq_pkg::S_IDLE |-> !s_tready)
    else $error("request taken while a query runs");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    quick_result && req_type == rmq_pkg::REQ_LOAD && store_full |=>
      m_tvalid && m_tuser == rmq_pkg::ST_FULL)
    else $error("full store load not flagged");

endmodule
`default_nettype wire

>>> src/rmq_store.sv
// rmq_store: sample memory and group summary memory, one write and one read port each
// depends on rmq_pkg; read data is registered and arrives in the cycle after the read request
`timescale 1ns / 1ps
`default_nettype none
module rmq_store (
  input  wire                        clk,
  input  wire                        rst,
  input  wire rmq_pkg::store_wr_t    wr,
  input  wire rmq_pkg::store_rd_t    rd,
  output rmq_pkg::store_rdata_t      rdata
);

  logic [rmq_pkg::SMP_W-1:0]   smp_mem [rmq_pkg::SAMPLE_DEPTH];
  logic [2*rmq_pkg::SMP_W-1:0] grp_mem [rmq_pkg::NUM_GROUPS];

  logic [rmq_pkg::SMP_W-1:0]   smp_q;
  logic [2*rmq_pkg::SMP_W-1:0] grp_q;
  logic                        rd_grp;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      smp_mem[wr.addr] <= wr.sample;
      grp_mem[wr.addr[rmq_pkg::ADDR_W-1:rmq_pkg::OFS_W]] <= {wr.grp_max, wr.grp_min};
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      smp_q  <= smp_mem[rd.addr];
      grp_q  <= grp_mem[rd.addr[rmq_pkg::ADDR_W-1:rmq_pkg::OFS_W]];
      rd_grp <= rd.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd.en;
    end
  end

  always_comb begin
    rdata.vld = rd_vld;
    rdata.lo  = rd_grp ? grp_q[rmq_pkg::SMP_W-1:0] : smp_q;
    rdata.hi  = rd_grp ? grp_q[2*rmq_pkg::SMP_W-1:rmq_pkg::SMP_W] : smp_q;
  end

endmodule
`default_nettype wire
